### rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    // Number of control loops that hold metrics.
    localparam int LOOP_COUNT = 16;
    localparam int IDX_W      = (LOOP_COUNT > 1) ? $clog2(LOOP_COUNT) : 1;

    localparam int DATA_W = 32;          // Q16.16 input words
    localparam int PROD_W = 2 * DATA_W;  // full multiplier product
    localparam int ACC_W  = 48;          // Q32.16 integrals
    localparam int OVS_W  = 31;          // Q15.16 overshoot percent
    localparam int SQ_W   = 47;          // (|e|^2) >> 16 fits in 47 bits
    localparam int SQ_HI_W = SQ_W - DATA_W;

    // The overshoot dividend (|pv-sp| * 100 * 65536) is below 2^55.
    localparam int DIVIDEND_W = 55;
    localparam int DIV_STEPS  = OVS_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // 0.0001 in Q16.16 is 6.5536 raw, so the setpoint guard is raw >= 7.
    localparam logic [DATA_W-1:0] SP_MIN    = 32'd7;
    localparam logic [DATA_W-1:0] OVS_SCALE = 32'd6553600;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_MUL_E,
        ST_MUL_F,
        ST_SQ_ADD,
        ST_DIV,
        ST_OVS,
        ST_WRITE
    } state_t;

    typedef enum logic [2:0] {
        MUL_ABS,
        MUL_SQUARE,
        MUL_SQ_LO,
        MUL_SQ_HI,
        MUL_OVS
    } mul_op_t;

    typedef struct packed {
        logic [ACC_W-1:0] abs_sum;
        logic [ACC_W-1:0] sq_sum;
        logic [OVS_W-1:0] ovs;
    } metrics_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic    accept;
        logic    load;
        logic    acc_abs;
        logic    latch_sq;
        logic    latch_lo;
        logic    form_term;
        logic    acc_sq;
        logic    div_init;
        logic    div_step;
        logic    ovs_upd;
        logic    write;
        mul_op_t mul_op;
    } ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic upd;
        logic ovs_ok;
        logic ovs_sat;
    } stat_t;

endpackage

`default_nettype wire

### rtl/lpm_mult.sv
`default_nettype none

module lpm_mult (
    input  wire logic                       clk,
    input  wire logic [lpm_pkg::DATA_W-1:0] a,
    input  wire logic [lpm_pkg::DATA_W-1:0] b,
    output logic      [lpm_pkg::PROD_W-1:0] p
);
    import lpm_pkg::*;

    logic [PROD_W-1:0] p_reg;

    // Unsigned 32x32 product, registered.
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### rtl/lpm_store.sv
`default_nettype none

module lpm_store (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [lpm_pkg::IDX_W-1:0] rd_addr,
    output lpm_pkg::metrics_t              rd_data,
    input  wire logic                      wr_en,
    input  wire logic [lpm_pkg::IDX_W-1:0] wr_addr,
    input  wire lpm_pkg::metrics_t         wr_data
);
    import lpm_pkg::*;

    metrics_t                mem [LOOP_COUNT];
    logic [LOOP_COUNT-1:0]   valid_reg;
    metrics_t                rd_data_reg;

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/lpm_ctrl.sv
`default_nettype none

module lpm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire lpm_pkg::stat_t stat,
    output lpm_pkg::ctl_t       ctl
);
    import lpm_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               div_last;

    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_LOAD;
            ST_LOAD:   state_next = stat.upd ? ST_MUL_A : ST_WRITE;
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_MUL_C;
            ST_MUL_C:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_E;
            ST_MUL_E:  state_next = ST_MUL_F;
            ST_MUL_F:  state_next = ST_SQ_ADD;
            ST_SQ_ADD:
            begin
                priority if (!stat.ovs_ok)
                    state_next = ST_WRITE;
                else if (stat.ovs_sat)
                    state_next = ST_OVS;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:    if (div_last) state_next = ST_OVS;
            ST_OVS:    state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl      = '0;
        ctl.mul_op = MUL_ABS;
        cnt_next = cnt_reg;
        busy     = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:   ctl.accept = start;
            ST_LOAD:   ctl.load = 1'b1;
            ST_MUL_A:  ctl.mul_op = MUL_ABS;
            ST_MUL_B:
            begin
                ctl.mul_op  = MUL_SQUARE;
                ctl.acc_abs = 1'b1;
            end
            ST_MUL_C:  ctl.latch_sq = 1'b1;
            ST_MUL_D:  ctl.mul_op = MUL_SQ_LO;
            ST_MUL_E:
            begin
                ctl.mul_op   = MUL_SQ_HI;
                ctl.latch_lo = 1'b1;
            end
            ST_MUL_F:
            begin
                ctl.mul_op    = MUL_OVS;
                ctl.form_term = 1'b1;
            end
            ST_SQ_ADD:
            begin
                ctl.acc_sq   = 1'b1;
                ctl.div_init = 1'b1;
                cnt_next     = '0;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_OVS:    ctl.ovs_upd = 1'b1;
            ST_WRITE:  ctl.write = 1'b1;
            default:   ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/lpm_dpath.sv
`default_nettype none

module lpm_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lpm_pkg::ctl_t                     ctl,
    output lpm_pkg::stat_t                         stat,
    input  wire logic [1:0]                        command,
    input  wire logic [3:0]                        loop_index,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] measured,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] target,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] deviation,
    input  wire logic [lpm_pkg::DATA_W-1:0]        step_time,
    input  wire lpm_pkg::metrics_t                 rd_data,
    output logic                                   wr_en,
    output logic [lpm_pkg::IDX_W-1:0]              wr_addr,
    output lpm_pkg::metrics_t                      wr_data,
    output logic                                   done,
    output logic [3:0]                             loop_echo,
    output logic [lpm_pkg::ACC_W-1:0]              abs_error_integral,
    output logic [lpm_pkg::ACC_W-1:0]              squared_error_integral,
    output logic [lpm_pkg::OVS_W-1:0]              peak_overshoot
);
    import lpm_pkg::*;

    // Latched transaction.
    logic [1:0]          cmd_reg;
    logic [3:0]          idx_reg;
    logic [DATA_W-1:0]   meas_reg;
    logic [DATA_W-1:0]   targ_reg;
    logic [DATA_W-1:0]   dev_reg;
    logic [DATA_W-1:0]   dt_reg;

    // Operands prepared in the load step.
    logic [DATA_W-1:0]   emag_reg;
    logic [DATA_W-1:0]   tmag_reg;
    logic [DATA_W-1:0]   nmag_reg;
    logic                ovs_ok_reg;

    metrics_t            acc_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [PROD_W-1:0]   lo_reg;
    logic [ACC_W-1:0]    term_reg;

    logic [DATA_W-1:0]   rem_reg;
    logic [OVS_W-1:0]    dlo_reg;
    logic [OVS_W-1:0]    quo_reg;

    logic                done_reg;
    logic [3:0]          echo_reg;
    metrics_t            res_reg;

    logic                in_range;
    logic [DATA_W-1:0]   emag_next;
    logic [DATA_W-1:0]   tmag_next;
    logic signed [DATA_W:0] diff_next;
    logic [DATA_W-1:0]   nmag_next;
    logic                ovs_ok_next;

    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [PROD_W-1:0]   prod;

    logic [ACC_W:0]      abs_sum_next;
    logic [ACC_W:0]      sq_sum_next;
    logic [PROD_W+SQ_HI_W:0] sq_full;
    logic [DATA_W:0]     rem_shift;
    logic                rem_ge;
    logic [DATA_W-1:0]   rem_next;

    assign in_range = (32'(idx_reg) < LOOP_COUNT);

    assign emag_next = dev_reg[DATA_W-1]  ? (~dev_reg + 1'b1)  : dev_reg;
    assign tmag_next = targ_reg[DATA_W-1] ? (~targ_reg + 1'b1) : targ_reg;
    assign diff_next = $signed({meas_reg[DATA_W-1], meas_reg})
                     - $signed({targ_reg[DATA_W-1], targ_reg});
    assign nmag_next = diff_next[DATA_W] ? DATA_W'(-diff_next) : diff_next[DATA_W-1:0];
    // Overshoot counts only when the error has the setpoint's sign.
    assign ovs_ok_next = (tmag_next >= SP_MIN) && (diff_next != '0)
                       && (diff_next[DATA_W] == targ_reg[DATA_W-1]);

    always_comb
    begin
        unique case (ctl.mul_op)
            MUL_ABS:
            begin
                mul_a = emag_reg;
                mul_b = dt_reg;
            end
            MUL_SQUARE:
            begin
                mul_a = emag_reg;
                mul_b = emag_reg;
            end
            MUL_SQ_LO:
            begin
                mul_a = sq_reg[DATA_W-1:0];
                mul_b = dt_reg;
            end
            MUL_SQ_HI:
            begin
                mul_a = DATA_W'(sq_reg[SQ_W-1:DATA_W]);
                mul_b = dt_reg;
            end
            MUL_OVS:
            begin
                mul_a = nmag_reg;
                mul_b = OVS_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lpm_mult u_mult (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // The absolute-error product is below 2^63, so its Q32.16 term fits 48 bits.
    assign abs_sum_next = {1'b0, acc_reg.abs_sum} + {1'b0, prod[PROD_W-2:16]};
    assign sq_sum_next  = {1'b0, acc_reg.sq_sum} + {1'b0, term_reg};
    // Recombine the split square-times-dt product.
    assign sq_full = (PROD_W+SQ_HI_W+1)'(lo_reg)
                   + {prod[SQ_HI_W+DATA_W-1:0], {DATA_W{1'b0}}};

    assign rem_shift = {rem_reg, dlo_reg[OVS_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, tmag_reg});
    assign rem_next  = rem_ge ? DATA_W'(rem_shift - {1'b0, tmag_reg}) : rem_shift[DATA_W-1:0];

    always_comb
    begin
        stat.upd     = in_range && (cmd_reg == CMD_UPDATE);
        stat.ovs_ok  = ovs_ok_reg;
        // A quotient of 2^31 or more saturates.
        stat.ovs_sat = (DATA_W'(prod[DIVIDEND_W-1:OVS_W]) >= tmag_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= command;
            idx_reg  <= loop_index;
            meas_reg <= measured;
            targ_reg <= target;
            dev_reg  <= deviation;
            dt_reg   <= step_time;
        end
        if (ctl.load)
        begin
            emag_reg   <= emag_next;
            tmag_reg   <= tmag_next;
            nmag_reg   <= nmag_next;
            ovs_ok_reg <= ovs_ok_next;
            if (!in_range || (cmd_reg == CMD_CLEAR))
                acc_reg <= '0;
            else
                acc_reg <= rd_data;
        end
        if (ctl.acc_abs)
        begin
            acc_reg.abs_sum <= abs_sum_next[ACC_W] ? '1 : abs_sum_next[ACC_W-1:0];
        end
        if (ctl.latch_sq)
        begin
            sq_reg <= prod[SQ_W+15:16];
        end
        if (ctl.latch_lo)
        begin
            lo_reg <= prod;
        end
        if (ctl.form_term)
        begin
            term_reg <= (|sq_full[PROD_W+SQ_HI_W:ACC_W+16]) ? '1 : sq_full[ACC_W+15:16];
        end
        if (ctl.acc_sq)
        begin
            acc_reg.sq_sum <= sq_sum_next[ACC_W] ? '1 : sq_sum_next[ACC_W-1:0];
        end
        if (ctl.div_init)
        begin
            rem_reg <= DATA_W'(prod[DIVIDEND_W-1:OVS_W]);
            dlo_reg <= prod[OVS_W-1:0];
            quo_reg <= '1;
        end
        if (ctl.div_step)
        begin
            rem_reg <= rem_next;
            dlo_reg <= {dlo_reg[OVS_W-2:0], 1'b0};
            quo_reg <= {quo_reg[OVS_W-2:0], rem_ge};
        end
        if (ctl.ovs_upd && (quo_reg > acc_reg.ovs))
        begin
            acc_reg.ovs <= quo_reg;
        end
        if (ctl.write)
        begin
            echo_reg <= idx_reg;
            res_reg  <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.write;
    end

    assign wr_en   = ctl.write && in_range;
    assign wr_addr = IDX_W'(idx_reg);
    assign wr_data = acc_reg;

    assign done                   = done_reg;
    assign loop_echo              = echo_reg;
    assign abs_error_integral     = res_reg.abs_sum;
    assign squared_error_integral = res_reg.sq_sum;
    assign peak_overshoot         = res_reg.ovs;

endmodule

`default_nettype wire

### rtl/loop_performance_metrics.sv
// Read and clear pass through load and write-back only; an update also runs the shared 32x32
// multiplier sequence and, unless the overshoot is skipped or saturates, the one-bit-per-cycle
// restoring divider (31 steps) for the overshoot percent. A new transaction is accepted only
// once the previous one has finished.
// Reset (rst_n, asynchronous, active low) zeroes every loop's metrics and idles the sequencer.
// Results are strobed for one cycle on done; the receiver cannot stall them.
`default_nettype none

module loop_performance_metrics (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        command,
    input  wire logic [3:0]                        loop_index,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] measured,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] target,
    input  wire logic signed [lpm_pkg::DATA_W-1:0] deviation,
    input  wire logic [lpm_pkg::DATA_W-1:0]        step_time,
    output logic                                   done,
    output logic [3:0]                             loop_echo,
    output logic [lpm_pkg::ACC_W-1:0]              abs_error_integral,
    output logic [lpm_pkg::ACC_W-1:0]              squared_error_integral,
    output logic [lpm_pkg::OVS_W-1:0]              peak_overshoot
);
    import lpm_pkg::*;

    // The sequencer steps an update through load, five multiplier issues,
    // the accumulate steps, the overshoot division and the write-back; a
    // read or clear goes from load to write-back. It tells the datapath what
    // to do each cycle through ctl and branches on the datapath's stat flags.
    ctl_t       ctl;
    stat_t      stat;

    // Metric store port signals. The read is launched on the accepting edge
    // so that the stored metrics are ready in the load step.
    metrics_t           rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    metrics_t           wr_data;
    logic               accept;

    assign accept = start && !busy;

    lpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    // The store keeps the two 48-bit integrals and the peak overshoot for
    // each loop. Valid bits cleared by reset make untouched loops read zero.
    lpm_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (IDX_W'(loop_index)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // The datapath owns the shared multiplier, the saturating accumulators
    // and the divider. Loops beyond the loop count report zero metrics and
    // are never written. An unused command code acts as a read.
    lpm_dpath u_dpath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .ctl                    (ctl),
        .stat                   (stat),
        .command                (command),
        .loop_index             (loop_index),
        .measured               (measured),
        .target                 (target),
        .deviation              (deviation),
        .step_time              (step_time),
        .rd_data                (rd_data),
        .wr_en                  (wr_en),
        .wr_addr                (wr_addr),
        .wr_data                (wr_data),
        .done                   (done),
        .loop_echo              (loop_echo),
        .abs_error_integral     (abs_error_integral),
        .squared_error_integral (squared_error_integral),
        .peak_overshoot         (peak_overshoot)
    );

endmodule

`default_nettype wire

### rtl/lpm_checker.sv
`default_nettype none

module lpm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // The result is strobed in the first idle cycle after a transaction.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    // Every finished transaction produces exactly one strobe.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

bind loop_performance_metrics lpm_checker u_lpm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

### sim/loop_performance_metrics_test.sv
`timescale 1ns / 1ps

module loop_performance_metrics_test;

    import lpm_pkg::*;

    // The block decodes command 3 as a read. The package names only the three used codes.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [ACC_W-1:0] ACC_FULL = '1;
    localparam logic [OVS_W-1:0] OVS_FULL = '1;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1725;
    localparam int CALM_TAIL     = 200;   // final random transactions sent back to back
    localparam int DRAIN_LIMIT   = 2000;  // cycles allowed for the last results to show up
    localparam int SETTLE_CYCLES = 50;    // longest update is one that runs the overshoot division

    // One result of the block: the loop and its three metrics after the transaction.
    typedef struct packed {
        logic [3:0]       loop_id;
        logic [ACC_W-1:0] abs_sum;
        logic [ACC_W-1:0] sq_sum;
        logic [OVS_W-1:0] peak;
    } loop_metrics_t;

    // One row of the directed table. When pinned is set, the result is typed in
    // by hand; otherwise it comes from the metrics model below.
    typedef struct packed {
        logic [1:0]       cmd;
        logic [3:0]       idx;
        logic [31:0]      pv;
        logic [31:0]      sp;
        logic [31:0]      err;
        logic [31:0]      dt;
        logic             pinned;
        logic [ACC_W-1:0] want_abs;
        logic [ACC_W-1:0] want_sq;
        logic [OVS_W-1:0] want_peak;
    } stim_row_t;

    // Directed transactions. The loops start at zero, so most of the results can be
    // worked out by hand. Q16.16 values: 1.0 is 32'h0001_0000.
    localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // Reads right after reset return zero metrics, at both ends of the loop range.
        '{CMD_READ, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        '{CMD_READ, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 48'h0, 48'h0, 31'd0},
        // An error of 1.0 over 1.0 s adds 1.0 to both integrals. A zero setpoint skips
        // the overshoot.
        '{CMD_UPDATE, 4'd1, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
          1'b1, 48'h1_0000, 48'h1_0000, 31'd0},
        // Process value 1.5 against setpoint 1.0 is a 50 percent overshoot.
        '{CMD_UPDATE, 4'd1, 32'h0001_8000, 32'h0001_0000, 32'h0, 32'h0,
          1'b1, 48'h1_0000, 48'h1_0000, 31'd3276800},
        // The most negative error with the longest interval drives loop 2 into
        // saturation on both integrals.
        '{CMD_UPDATE, 4'd2, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd2, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd2, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
          1'b1, ACC_FULL, ACC_FULL, 31'd0},
        // A clear reports the zeroed loop. The other fields are ignored.
        '{CMD_CLEAR, 4'd2, 32'h1234_5678, 32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 48'h0, 48'h0, 31'd0},
        // The smallest setpoint that passes the guard, with a huge process value,
        // saturates the overshoot.
        '{CMD_UPDATE, 4'd3, 32'h7FFF_FFFF, 32'h0000_0007, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, OVS_FULL},
        // One count below the guard, the overshoot is not evaluated.
        '{CMD_UPDATE, 4'd4, 32'h7FFF_FFFF, 32'h0000_0006, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        // With a negative setpoint, a more negative process value is an overshoot.
        '{CMD_UPDATE, 4'd5, 32'h8000_0000, 32'hFFFF_FFF9, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, OVS_FULL},
        // Opposite signs, equal values and an undershoot all leave the peak at zero.
        '{CMD_UPDATE, 4'd6, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd6, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd7, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        // A 25 percent overshoot does not lower the 50 percent peak of loop 1.
        '{CMD_UPDATE, 4'd1, 32'h0001_4000, 32'h0001_0000, 32'h0, 32'h0,
          1'b1, 48'h1_0000, 48'h1_0000, 31'd3276800},
        // The most negative setpoint with the largest process value is the wrong sign.
        '{CMD_UPDATE, 4'd8, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        // The unused command code acts as a read, even with update fields at full scale.
        '{CMD_SPARE, 4'd1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 48'h1_0000, 48'h1_0000, 31'd3276800},
        '{CMD_READ, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 48'h1_0000, 48'h1_0000, 31'd3276800},
        // Largest positive error with the smallest interval, then the smallest negative
        // error with the largest interval.
        '{CMD_UPDATE, 4'd9, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0000_0001,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd9, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_UPDATE, 4'd10, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
          1'b0, 48'h0, 48'h0, 31'd0},
        '{CMD_CLEAR, 4'd1, 32'h0, 32'h0, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, 31'd0},
        '{CMD_READ, 4'd3, 32'h0, 32'h0, 32'h0, 32'h0,
          1'b1, 48'h0, 48'h0, OVS_FULL},
        '{CMD_UPDATE, 4'd15, 32'hFFFE_8000, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0001_8000,
          1'b0, 48'h0, 48'h0, 31'd0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               command = CMD_READ;
    logic [3:0]               loop_index = '0;
    logic signed [DATA_W-1:0] measured = '0;
    logic signed [DATA_W-1:0] target = '0;
    logic signed [DATA_W-1:0] deviation = '0;
    logic [DATA_W-1:0]        step_time = '0;
    logic                     done;
    logic [3:0]               loop_echo;
    logic [ACC_W-1:0]         abs_error_integral;
    logic [ACC_W-1:0]         squared_error_integral;
    logic [OVS_W-1:0]         peak_overshoot;

    // Hand-typed result that travels with the transaction on the input side.
    logic                     row_pinned = 1'b0;
    logic [ACC_W-1:0]         pinned_abs = '0;
    logic [ACC_W-1:0]         pinned_sq = '0;
    logic [OVS_W-1:0]         pinned_peak = '0;

    // Metrics model state, one entry per loop.
    logic [ACC_W-1:0]         abs_store [LOOP_COUNT];
    logic [ACC_W-1:0]         square_store [LOOP_COUNT];
    logic [OVS_W-1:0]         peak_store [LOOP_COUNT];

    loop_metrics_t            pending_metrics [$];
    int                       mismatch_count = 0;

    loop_performance_metrics uut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .command                (command),
        .loop_index             (loop_index),
        .measured               (measured),
        .target                 (target),
        .deviation              (deviation),
        .step_time              (step_time),
        .done                   (done),
        .loop_echo              (loop_echo),
        .abs_error_integral     (abs_error_integral),
        .squared_error_integral (squared_error_integral),
        .peak_overshoot         (peak_overshoot)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Adds a term to a 48-bit integral. Both the term and the sum clamp at full scale.
    function automatic logic [ACC_W-1:0] saturating_sum(input logic [ACC_W-1:0] acc,
                                                        input longint unsigned term);
        longint unsigned total;
        total = (term > ACC_FULL) ? longint'(ACC_FULL) : term;
        total += acc;
        return (total > ACC_FULL) ? ACC_FULL : total[ACC_W-1:0];
    endfunction

    // Applies one transaction to the model state and returns the metrics that the
    // block should report for it.
    function automatic loop_metrics_t metrics_after(input logic [1:0] cmd,
                                                    input logic [3:0] idx,
                                                    input logic signed [31:0] pv,
                                                    input logic signed [31:0] sp,
                                                    input logic signed [31:0] err,
                                                    input logic [31:0] dt);
        loop_metrics_t   res;
        longint signed   err_val;
        longint signed   sp_val;
        longint signed   diff;
        longint unsigned err_mag;
        longint unsigned sq_base;
        longint unsigned sq_term;
        longint unsigned sp_mag;
        longint unsigned diff_mag;
        longint unsigned quot;
        res = '0;
        res.loop_id = idx;
        if (idx >= LOOP_COUNT)
        begin
            return res;
        end
        if (cmd == CMD_UPDATE)
        begin
            // Integrals: |e|*dt in Q32.16, then (e*e >> 16) * dt >> 16, both truncated.
            err_val = err;
            err_mag = (err_val < 0) ? -err_val : err_val;
            sq_base = (err_mag * err_mag) >> 16;
            sq_term = sq_base * (dt >> 16) + ((sq_base * dt[15:0]) >> 16);
            abs_store[idx] = saturating_sum(abs_store[idx], (err_mag * dt) >> 16);
            square_store[idx] = saturating_sum(square_store[idx], sq_term);

            // Overshoot percent, only for setpoints clear of zero and only when the
            // process value lies beyond the setpoint on the setpoint's own side.
            sp_val = sp;
            sp_mag = (sp_val < 0) ? -sp_val : sp_val;
            diff = longint'(pv) - sp_val;
            if (sp_mag >= SP_MIN && diff != 0 && ((diff < 0) == (sp_val < 0)))
            begin
                diff_mag = (diff < 0) ? -diff : diff;
                quot = (diff_mag * OVS_SCALE) / sp_mag;
                if (quot > OVS_FULL)
                begin
                    quot = OVS_FULL;
                end
                if (quot > peak_store[idx])
                begin
                    peak_store[idx] = quot[OVS_W-1:0];
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            abs_store[idx] = '0;
            square_store[idx] = '0;
            peak_store[idx] = '0;
        end
        res.abs_sum = abs_store[idx];
        res.sq_sum = square_store[idx];
        res.peak = peak_store[idx];
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] expected,
                                 input logic [63:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected,
                     actual);
            mismatch_count++;
        end
    endtask

    // Presents one transaction and holds it until the edge that accepts it. The
    // caller either presents the next one right away or drops start.
    task automatic issue(input logic [1:0] cmd, input logic [3:0] idx,
                         input logic [31:0] pv, input logic [31:0] sp,
                         input logic [31:0] err, input logic [31:0] dt,
                         input logic pin, input logic [ACC_W-1:0] pin_abs,
                         input logic [ACC_W-1:0] pin_sq, input logic [OVS_W-1:0] pin_peak);
        command     <= cmd;
        loop_index  <= idx;
        measured    <= pv;
        target      <= sp;
        deviation   <= err;
        step_time   <= dt;
        row_pinned  <= pin;
        pinned_abs  <= pin_abs;
        pinned_sq   <= pin_sq;
        pinned_peak <= pin_peak;
        start       <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the sender off until every outstanding result has come back. The first
    // edge lets the scoreboard record the transaction that was just accepted.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_metrics.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random word that favors small and medium magnitudes of either sign, with the
    // corner values mixed in.
    function automatic logic [31:0] shaped_word();
        logic [31:0] mag;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: mag = $urandom_range(0, 32'h0001_0000);
            2: mag = $urandom_range(0, 32'h0040_0000);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Result checking and prediction. Both look at the values from before the edge:
    // a result is taken on every edge where done is high, and a transaction is
    // accepted on every edge where start is high and busy is low.
    always @(posedge clk)
    begin : scoreboard
        loop_metrics_t want;
        if (rst_n && done)
        begin
            if (pending_metrics.size() == 0)
            begin
                $display("%0t: result for loop %0d with no transaction pending, expected none",
                         $time, loop_echo);
                mismatch_count++;
            end
            else
            begin
                want = pending_metrics.pop_front();
                compare_field("loop_echo", want.loop_id, loop_echo);
                compare_field("abs_error_integral", want.abs_sum, abs_error_integral);
                compare_field("squared_error_integral", want.sq_sum, squared_error_integral);
                compare_field("peak_overshoot", want.peak, peak_overshoot);
            end
        end
        if (rst_n && start && !busy)
        begin
            want = metrics_after(command, loop_index, measured, target, deviation, step_time);
            if (row_pinned)
            begin
                want.abs_sum = pinned_abs;
                want.sq_sum = pinned_sq;
                want.peak = pinned_peak;
            end
            pending_metrics.push_back(want);
        end
    end

    initial
    begin : stimulus
        stim_row_t   row;
        int          gap_pct;
        int          sel;
        int          wait_cycles;
        logic [1:0]  cmd;
        logic [31:0] sp;
        logic [31:0] pv;
        logic [31:0] sp_mag;
        logic [31:0] offset;
        logic [31:0] dt;

        for (int i = 0; i < LOOP_COUNT; i++)
        begin
            abs_store[i] = '0;
            square_store[i] = '0;
            peak_store[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with occasional sender gaps.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = DIRECTED_TABLE[r];
            issue(row.cmd, row.idx, row.pv, row.sp, row.err, row.dt,
                  row.pinned, row.want_abs, row.want_sq, row.want_peak);
            if ($urandom_range(1, 100) <= 30)
            begin
                pause_sender($urandom_range(1, 17));
            end
        end

        // Let the directed results settle before the random part starts.
        drain_results();

        // Random part. Most transactions are updates with a setpoint well clear of
        // zero and a process value near it, so the overshoot divider runs and the
        // peak climbs gradually. Clears keep the integrals from sitting at full scale.
        gap_pct = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                gap_pct = $urandom_range(0, 3) * 20;
            end
            if (n >= RANDOM_ITEMS - CALM_TAIL)
            begin
                gap_pct = 0;
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                drain_results();
            end

            sel = $urandom_range(0, 99);
            if (sel < 72)
            begin
                cmd = CMD_UPDATE;
            end
            else if (sel < 80)
            begin
                cmd = CMD_CLEAR;
            end
            else if (sel < 95)
            begin
                cmd = CMD_READ;
            end
            else
            begin
                cmd = CMD_SPARE;
            end

            dt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);

            case ($urandom_range(0, 9))
                0:
                begin
                    // Noise on the setpoint and process value.
                    sp = shaped_word();
                    pv = shaped_word();
                end
                1:
                begin
                    // Setpoints around the guard threshold.
                    sp_mag = $urandom_range(0, 14);
                    sp = $urandom_range(0, 1) ? -sp_mag : sp_mag;
                    pv = $urandom;
                end
                default:
                begin
                    sp_mag = $urandom_range(7, 32'h0100_0000);
                    offset = $urandom_range(0, sp_mag / 2);
                    sp = $urandom_range(0, 1) ? -sp_mag : sp_mag;
                    pv = $urandom_range(0, 1) ? sp + offset : sp - offset;
                end
            endcase

            issue(cmd, 4'($urandom_range(0, 15)), pv, sp, shaped_word(), dt,
                  1'b0, '0, '0, '0);
            if ($urandom_range(1, 100) <= gap_pct)
            begin
                pause_sender($urandom_range(1, 17));
            end
        end

        // Wind down: wait for the last results, then a little longer to catch strays.
        start <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (pending_metrics.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_metrics.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                     $time, pending_metrics.size(), pending_metrics.size());
            mismatch_count += pending_metrics.size();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is well under half a millisecond.
    initial
    begin : watchdog
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/lpm_pkg.sv
rtl/lpm_mult.sv
rtl/lpm_store.sv
rtl/lpm_ctrl.sv
rtl/lpm_dpath.sv
rtl/loop_performance_metrics.sv
rtl/lpm_checker.sv
sim/loop_performance_metrics_test.sv
